// File: rtl/tdbs_pkg.sv
// Shared types and constants for the triangle depth bucket sorter.
// Used by the vertex lane, merge stage and the top level.
package tdbs_pkg;

   localparam int MAX_TRIANGLES_DEF = 512;
   localparam int BUCKET_COUNT_DEF  = 256;

   // datapath widths
   localparam int CRD_W  = 16;  // screen coordinate / box
   localparam int ZW     = 19;  // view depth
   localparam int XW     = 19;  // rotated x
   localparam int YW     = 17;  // offset y
   localparam int PNW    = 27;  // projection numerator (coord * 256)
   localparam int SUM_W  = 18;  // depth sum of a kept triangle

   // mean = floor(sum / 3) for sum < 2**19
   localparam logic [17:0] MEAN_RECIP = 18'd174763;
   localparam int          MEAN_SHIFT = 19;

   localparam logic signed [ZW-1:0] Z_CLAMP = 19'sd128;

   typedef enum logic [2:0] {
      CFG_SIN  = 3'd0,
      CFG_COS  = 3'd1,
      CFG_NEAR = 3'd2,
      CFG_FAR  = 3'd3,
      CFG_FYO  = 3'd4,
      CFG_VZO  = 3'd5,
      CFG_CX   = 3'd6,
      CFG_CY   = 3'd7
   } cfg_idx_type;

   typedef struct packed {
      logic                    done;
      logic signed [ZW-1:0]    z;
      logic signed [CRD_W-1:0] px;
      logic signed [CRD_W-1:0] py;
   } lane_stat_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] min_x;
      logic signed [CRD_W-1:0] max_x;
      logic signed [CRD_W-1:0] min_y;
      logic signed [CRD_W-1:0] max_y;
   } box_type;

endpackage

// File: rtl/tdbs_div.sv
// Radix-2 restoring divider, signed numerator, unsigned divisor, one bit a cycle.
// Quotient truncates toward zero. Depends on nothing outside this file.
module tdbs_div #(
   parameter int NW = 27,
   parameter int DW = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic signed [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] mag_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          neg_ff;
   logic          run_ff;
   logic          done_ff;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   assign trial = {rem_ff, mag_ff[NW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mag_ff <= num[NW-1] ? NW'(-num) : NW'(num);
            neg_ff <= num[NW-1];
            rem_ff <= '0;
            den_ff <= den;
            cnt_ff <= CW'(NW);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            // quotient bits shift in behind the numerator bits
            mag_ff <= {mag_ff[NW-2:0], ge};
            rem_ff <= ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule

// File: rtl/tdbs_lane.sv
// One vertex lane: yaw rotation, offsets and perspective projection.
// Depends on tdbs_pkg and tdbs_div.
module tdbs_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [15:0]    vx,
   input  logic signed [15:0]    vy,
   input  logic signed [15:0]    vz,
   input  logic signed [17:0]    sin_val,
   input  logic signed [17:0]    cos_val,
   input  logic signed [15:0]    fyo,
   input  logic signed [15:0]    vzo,
   input  logic [9:0]            cx,
   input  logic [9:0]            cy,
   output tdbs_pkg::lane_stat_type stat
);
   import tdbs_pkg::*;

   logic signed [33:0]    p0_ff, p1_ff, p2_ff, p3_ff;
   logic                  ph1_ff, ph2_ff, done_ff;
   logic signed [XW-1:0]  x_ff;
   logic signed [YW-1:0]  y_ff;
   logic signed [ZW-1:0]  z_ff;
   logic signed [CRD_W-1:0] px_ff, py_ff;
   logic signed [34:0]    sx, sz;
   logic signed [ZW-1:0]  zr;
   logic signed [PNW-1:0] nx, ny;
   logic [ZW-1:0]         zc;
   logic signed [PNW-1:0] qx, qy;
   logic                  dx_done, dy_done;

   // arithmetic shift of the 16.16 sums is a floor
   assign sx = {p0_ff[33], p0_ff} + {p1_ff[33], p1_ff};
   assign sz = {p3_ff[33], p3_ff} - {p2_ff[33], p2_ff};
   assign zr = sz[34:16] + {{3{vzo[15]}}, vzo};

   assign nx = {x_ff, 8'b0};
   assign ny = {{2{y_ff[YW-1]}}, y_ff, 8'b0};
   assign zc = (z_ff < Z_CLAMP) ? ZW'(Z_CLAMP) : ZW'(z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ph1_ff  <= 1'b0;
         ph2_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ph1_ff <= start;
         ph2_ff <= ph1_ff;
         if (start) begin
            done_ff <= 1'b0;
         end else if (dx_done) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         p0_ff <= vx * cos_val;
         p1_ff <= vz * sin_val;
         p2_ff <= vx * sin_val;
         p3_ff <= vz * cos_val;
      end
      if (ph1_ff) begin
         x_ff <= sx[34:16];
         z_ff <= zr;
         y_ff <= {vy[15], vy} - {fyo[15], fyo};
      end
      if (dx_done) begin
         px_ff <= $signed(CRD_W'({6'b0, cx}) + qx[CRD_W-1:0]);
         py_ff <= $signed(CRD_W'({6'b0, cy}) - qy[CRD_W-1:0]);
      end
   end

   tdbs_div #(.NW(PNW), .DW(ZW)) u_div_x (
      .clock (clock), .reset (reset), .start (ph2_ff),
      .num   (nx), .den (zc), .done (dx_done), .quo (qx)
   );

   tdbs_div #(.NW(PNW), .DW(ZW)) u_div_y (
      .clock (clock), .reset (reset), .start (ph2_ff),
      .num   (ny), .den (zc), .done (dy_done), .quo (qy)
   );

   always_comb begin
      stat.done = done_ff & ~(dy_done & ~dx_done);
      stat.z    = z_ff;
      stat.px   = px_ff;
      stat.py   = py_ff;
   end

endmodule

// File: rtl/tdbs_merge.sv
// Merge stage: depth window test, depth sum and bounding box widening
// over the three vertex lanes. Depends on tdbs_pkg.
module tdbs_merge (
   input  tdbs_pkg::lane_stat_type lanes [3],
   input  tdbs_pkg::box_type       box_in,
   input  logic [14:0]             near_lim,
   input  logic [15:0]             far_lim,
   output logic                    reject,
   output logic [17:0]             sum,
   output tdbs_pkg::box_type       box_out
);
   import tdbs_pkg::*;

   logic signed [ZW-1:0] mn, mx;
   logic signed [ZW+1:0] acc;

   always_comb begin
      mn      = lanes[0].z;
      mx      = lanes[0].z;
      acc     = '0;
      box_out = box_in;
      for (int k = 0; k < 3; k++) begin
         if (lanes[k].z < mn) mn = lanes[k].z;
         if (lanes[k].z > mx) mx = lanes[k].z;
         acc = acc + {{2{lanes[k].z[ZW-1]}}, lanes[k].z};
         if (lanes[k].px < box_out.min_x) box_out.min_x = lanes[k].px;
         if (lanes[k].px > box_out.max_x) box_out.max_x = lanes[k].px;
         if (lanes[k].py < box_out.min_y) box_out.min_y = lanes[k].py;
         if (lanes[k].py > box_out.max_y) box_out.max_y = lanes[k].py;
      end
      reject = (mn < $signed({4'b0, near_lim})) || (mx > $signed({3'b0, far_lim}));
      sum    = acc[17:0];
   end

endmodule

// File: rtl/triangle_depth_bucket_sorter_core.sv
// Triangle depth bucket sorter: three vertex lanes, merge, bucket lists.
// Load: between accept and result a load passes the 27-step projection dividers and
//   the 25-step bucket divider; with equal limits or when rejected it skips the latter.
// Fetch: scans the buckets from the highest down, stepping over empty ones, and follows each list.
// One item at a time; the next is accepted while a result waits in the output register.
// Synchronous active-high reset; bucket lists are empty after reset, no clearing pass.
module triangle_depth_bucket_sorter_core #(
   parameter int MAX_TRIANGLES = tdbs_pkg::MAX_TRIANGLES_DEF,
   parameter int BUCKET_COUNT  = tdbs_pkg::BUCKET_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
   input  logic [143:0] req_tdata,
   // operation, start_frame
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // was_rejected, depth_bucket[8], draw_index[9], entry_valid, kept_count[10],
   // rejected_count[10], box_min_x, box_max_x, box_min_y, box_max_y, pad[1]
   output logic [103:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [17:0]  csr_wdata
);
   import tdbs_pkg::*;

   localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
   localparam int BK_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int BNW   = 16 + BK_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_LANE, ST_MEAN, ST_SCALE, ST_BDIV, ST_BWAIT, ST_TREAD,
      ST_LINKA, ST_LINKB, ST_SCAN, ST_HEADW, ST_EMIT, ST_LNKW, ST_OUT
   } state_type;

   // configuration
   logic signed [17:0] sin_ff, cos_ff;
   logic [14:0]        near_ff;
   logic [15:0]        far_ff;
   logic signed [15:0] fyo_ff, vzo_ff;
   logic [9:0]         cx_ff, cy_ff;

   state_type          state_ff;
   logic               op_ff, start_ff;
   logic signed [15:0] vx_ff [3];
   logic signed [15:0] vy_ff [3];
   logic signed [15:0] vz_ff [3];

   logic [CNT_W-1:0]   cnt_ff;
   logic [9:0]         rejcnt_ff;
   box_type            box_ff;
   logic               hv_ff [BUCKET_COUNT];
   logic [BK_W-1:0]    drain_bk_ff;
   logic               drain_done_ff;
   logic [IDX_W-1:0]   cursor_ff;
   logic               cv_ff;
   logic [BK_W-1:0]    bk_ff;
   logic               hvw_ff;
   logic [17:0]        sum_ff;
   logic [15:0]        mean_ff;
   logic [BNW-1:0]     bnum_ff;

   logic               res_rej_ff, res_valid_ff;
   logic [BK_W-1:0]    res_bk_ff;
   logic [IDX_W-1:0]   res_idx_ff;
   logic               rsp_valid_ff;
   logic [103:0]       rsp_data_ff;

   // memories
   logic [IDX_W-1:0]   heads_mem [BUCKET_COUNT];
   logic [IDX_W-1:0]   tails_mem [BUCKET_COUNT];
   logic [IDX_W:0]     links_mem [MAX_TRIANGLES];
   logic [IDX_W-1:0]   head_rd_ff, tail_rd_ff;
   logic [IDX_W:0]     link_rd_ff;

   lane_stat_type      lane_stat [3];
   logic               lane_go;
   logic               lanes_done;
   logic               m_reject;
   logic [17:0]        m_sum;
   box_type            m_box;
   logic               bdiv_go, bdiv_done;
   logic signed [BNW:0] bquo;
   logic [35:0]        mprod;
   logic [IDX_W-1:0]   new_idx;
   logic [31:0]        kept32, bk32, idx32;

   assign req_tready = (state_ff == ST_IDLE);
   assign lane_go    = (state_ff == ST_DISPATCH) && !op_ff && (cnt_ff < CNT_W'(MAX_TRIANGLES));
   assign lanes_done = lane_stat[0].done & lane_stat[1].done & lane_stat[2].done;
   // numerator is registered in ST_SCALE, divider starts in ST_BDIV, the state after it
   assign bdiv_go    = (state_ff == ST_BDIV);
   assign mprod      = sum_ff * MEAN_RECIP;
   assign new_idx    = cnt_ff[IDX_W-1:0];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sin_ff  <= '0;
         cos_ff  <= -18'sd65536;
         near_ff <= 15'd128;
         far_ff  <= 16'd2048;
         fyo_ff  <= 16'sd55;
         vzo_ff  <= 16'sd300;
         cx_ff   <= 10'd160;
         cy_ff   <= 10'd112;
      end else if (csr_we) begin
         unique case (cfg_idx_type'(csr_addr))
            CFG_SIN:  sin_ff  <= csr_wdata;
            CFG_COS:  cos_ff  <= csr_wdata;
            CFG_NEAR: near_ff <= csr_wdata[14:0];
            CFG_FAR:  far_ff  <= csr_wdata[15:0];
            CFG_FYO:  fyo_ff  <= csr_wdata[15:0];
            CFG_VZO:  vzo_ff  <= csr_wdata[15:0];
            CFG_CX:   cx_ff   <= csr_wdata[9:0];
            CFG_CY:   cy_ff   <= csr_wdata[9:0];
         endcase
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      tdbs_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (lane_go),
         .vx      (vx_ff[g]),
         .vy      (vy_ff[g]),
         .vz      (vz_ff[g]),
         .sin_val (sin_ff),
         .cos_val (cos_ff),
         .fyo     (fyo_ff),
         .vzo     (vzo_ff),
         .cx      (cx_ff),
         .cy      (cy_ff),
         .stat    (lane_stat[g])
      );
   end

   tdbs_merge u_merge (
      .lanes    (lane_stat),
      .box_in   (box_ff),
      .near_lim (near_ff),
      .far_lim  (far_ff),
      .reject   (m_reject),
      .sum      (m_sum),
      .box_out  (m_box)
   );

   tdbs_div #(.NW(BNW + 1), .DW(16)) u_bdiv (
      .clock (clock),
      .reset (reset),
      .start (bdiv_go),
      .num   ($signed({1'b0, bnum_ff})),
      .den   (far_ff - {1'b0, near_ff}),
      .done  (bdiv_done),
      .quo   (bquo)
   );

   // list memories, registered reads
   always_ff @(posedge clock) begin
      head_rd_ff <= heads_mem[drain_bk_ff];
      tail_rd_ff <= tails_mem[bk_ff];
      link_rd_ff <= links_mem[cursor_ff];
      if (state_ff == ST_LINKA) begin
         tails_mem[bk_ff] <= new_idx;
         if (!hv_ff[bk_ff]) heads_mem[bk_ff] <= new_idx;
      end
      if (state_ff == ST_LINKA) begin
         links_mem[new_idx] <= {1'b0, new_idx};
      end else if (state_ff == ST_LINKB && hvw_ff) begin
         links_mem[tail_rd_ff] <= {1'b1, new_idx};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rejcnt_ff     <= '0;
         box_ff        <= {16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768};
         drain_bk_ff   <= BK_W'(BUCKET_COUNT - 1);
         drain_done_ff <= 1'b0;
         cv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int b = 0; b < BUCKET_COUNT; b++) hv_ff[b] <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser[0];
                  start_ff <= req_tuser[1];
                  for (int k = 0; k < 3; k++) begin
                     vx_ff[k] <= req_tdata[48*k +: 16];
                     vy_ff[k] <= req_tdata[48*k+16 +: 16];
                     vz_ff[k] <= req_tdata[48*k+32 +: 16];
                  end
                  if (req_tuser[1]) begin
                     cnt_ff        <= '0;
                     rejcnt_ff     <= '0;
                     box_ff        <= {16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768};
                     drain_bk_ff   <= BK_W'(BUCKET_COUNT - 1);
                     drain_done_ff <= 1'b0;
                     cv_ff         <= 1'b0;
                     for (int b = 0; b < BUCKET_COUNT; b++) hv_ff[b] <= 1'b0;
                  end
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               // a load that finds the table full is ignored and flagged
               res_rej_ff   <= !op_ff && !lane_go;
               res_valid_ff <= 1'b0;
               res_bk_ff    <= '0;
               res_idx_ff   <= '0;
               if (!op_ff) begin
                  drain_bk_ff   <= BK_W'(BUCKET_COUNT - 1);
                  drain_done_ff <= 1'b0;
                  cv_ff         <= 1'b0;
                  if (lane_go) begin
                     state_ff <= ST_LANE;
                  end else begin
                     state_ff <= ST_OUT;
                  end
               end else if (cv_ff || drain_done_ff) begin
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_LANE: begin
               if (lanes_done) begin
                  if (m_reject) begin
                     res_rej_ff <= 1'b1;
                     rejcnt_ff  <= rejcnt_ff + 1'b1;
                     state_ff   <= ST_OUT;
                  end else begin
                     box_ff   <= m_box;
                     sum_ff   <= m_sum;
                     state_ff <= ST_MEAN;
                  end
               end
            end
            ST_MEAN: begin
               mean_ff  <= 16'(mprod >> MEAN_SHIFT);
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               bnum_ff <= (mean_ff - {1'b0, near_ff}) * BK_W'(BUCKET_COUNT - 1);
               if (far_ff > {1'b0, near_ff}) begin
                  state_ff <= ST_BDIV;
               end else begin
                  bk_ff    <= '0;
                  state_ff <= ST_TREAD;
               end
            end
            ST_BDIV: begin
               state_ff <= ST_BWAIT;
            end
            ST_BWAIT: begin
               if (bdiv_done) begin
                  bk_ff    <= bquo[BK_W-1:0];
                  state_ff <= ST_TREAD;
               end
            end
            ST_TREAD: begin
               state_ff <= ST_LINKA;
            end
            ST_LINKA: begin
               hvw_ff       <= hv_ff[bk_ff];
               hv_ff[bk_ff] <= 1'b1;
               state_ff     <= ST_LINKB;
            end
            ST_LINKB: begin
               cnt_ff    <= cnt_ff + 1'b1;
               res_bk_ff <= bk_ff;
               state_ff  <= ST_OUT;
            end
            ST_SCAN: begin
               if (drain_bk_ff == '0) begin
                  drain_done_ff <= 1'b1;
               end else begin
                  drain_bk_ff <= drain_bk_ff - 1'b1;
               end
               if (hv_ff[drain_bk_ff]) begin
                  state_ff <= ST_HEADW;
               end else if (drain_bk_ff == '0) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_HEADW: begin
               cursor_ff <= head_rd_ff;
               cv_ff     <= 1'b1;
               state_ff  <= ST_EMIT;
            end
            ST_EMIT: begin
               if (cv_ff) begin
                  res_idx_ff   <= cursor_ff;
                  res_valid_ff <= 1'b1;
                  state_ff     <= ST_LNKW;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_LNKW: begin
               cv_ff     <= link_rd_ff[IDX_W];
               cursor_ff <= link_rd_ff[IDX_W-1:0];
               state_ff  <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, box_ff.max_y, box_ff.min_y, box_ff.max_x,
                                   box_ff.min_x, rejcnt_ff, kept32[9:0], res_valid_ff,
                                   idx32[8:0], bk32[7:0], res_rej_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign kept32 = 32'(cnt_ff);
   assign bk32   = 32'(res_bk_ff);
   assign idx32  = 32'(res_idx_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_TRIANGLES))
      else $error("triangle count beyond table size");

   a_load_no_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> !rsp_tdata[18])
      else $error("rejected load reports a draw entry");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cnt_ff != '0) |->
         (box_ff.min_x <= box_ff.max_x && box_ff.min_y <= box_ff.max_y))
      else $error("bounding box inverted with kept triangles");
`endif

endmodule

// File: tb/sv/triangle_depth_bucket_sorter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for triangle_depth_bucket_sorter_core: a directed table, then random
// frames of loads and fetches, each checked against a behavioral depth sorter kept here.
// Depends on tdbs_pkg and the core RTL only.
module triangle_depth_bucket_sorter_core_tb;
   import tdbs_pkg::*;

   localparam int NTRI = 512;
   localparam int NBKT = 256;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef enum bit {OP_LOAD = 1'b0, OP_FETCH = 1'b1} op_type;

   typedef struct {
      bit               rej;
      bit [7:0]         bucket;
      bit [8:0]         idx;
      bit               valid;
      bit [9:0]         kept;
      bit [9:0]         rejn;
      bit signed [15:0] box[4];
   } sort_result_type;

   typedef struct {
      op_type           op;
      bit               sf;
      logic [143:0]     tri_data;
      bit               typed;
      sort_result_type  typed_res;
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [17:0]  csr_wdata = '0;

   triangle_depth_bucket_sorter_core dut (.*);

   always #2 clock = ~clock;

   // sorter shadow: registers
   logic signed [17:0] sin_r, cos_r;
   logic [14:0]        near_r;
   logic [15:0]        far_r;
   logic signed [15:0] fyo_r, vzo_r;
   logic [9:0]         cx_r, cy_r;
   // sorter shadow: lists and frame state
   bit       head_ok[NBKT];
   bit [8:0] heads[NBKT];
   bit [8:0] tails[NBKT];
   bit [8:0] links[NTRI];
   bit       link_ok[NTRI];
   int       tri_cnt, kept_n, rej_n;
   int       box_acc[4];
   int       drain_b;
   bit       drain_end, cur_ok;
   int       cursor;

   sort_result_type expected_q[$];
   int  mismatches = 0;
   int  rsp_count = 0;
   int  hold_left = 0;
   int  burst_left = 0;
   longint cycles = 0;

   function automatic void clear_frame();
      for (int b = 0; b < NBKT; b++) head_ok[b] = 0;
      tri_cnt = 0; kept_n = 0; rej_n = 0;
      box_acc[0] = 32767; box_acc[1] = -32768;
      box_acc[2] = 32767; box_acc[3] = -32768;
      drain_b = NBKT - 1; drain_end = 0; cur_ok = 0; cursor = 0;
   endfunction

   function automatic sort_result_type sort_step(op_type op, bit sf, logic [143:0] d);
      sort_result_type r;
      longint mx0, my0, mz0, x[3], y[3], z[3], mn, mx, mean, zc, p, bk;
      logic signed [15:0] w;
      int idx;
      r.rej = 0; r.bucket = 0; r.idx = 0; r.valid = 0;
      if (sf) clear_frame();
      if (op == OP_LOAD) begin
         drain_b = NBKT - 1; drain_end = 0; cur_ok = 0;
         if (tri_cnt >= NTRI) begin
            r.rej = 1;
         end else begin
            for (int k = 0; k < 3; k++) begin
               mx0 = longint'($signed(d[48*k +: 16]));
               my0 = longint'($signed(d[48*k+16 +: 16]));
               mz0 = longint'($signed(d[48*k+32 +: 16]));
               x[k] = (mx0 * longint'(cos_r) + mz0 * longint'(sin_r)) >>> 16;
               z[k] = ((-mx0 * longint'(sin_r) + mz0 * longint'(cos_r)) >>> 16)
                      + longint'(vzo_r);
               y[k] = my0 - longint'(fyo_r);
            end
            mn = z[0]; mx = z[0];
            for (int k = 1; k < 3; k++) begin
               if (z[k] < mn) mn = z[k];
               if (z[k] > mx) mx = z[k];
            end
            if (mn < longint'(near_r) || mx > longint'(far_r)) begin
               r.rej = 1;
               rej_n++;
            end else begin
               idx = tri_cnt;
               mean = (z[0] + z[1] + z[2]) / 3;
               for (int k = 0; k < 3; k++) begin
                  zc = (z[k] < 128) ? 128 : z[k];
                  p = longint'(cx_r) + (x[k] * 256) / zc;
                  w = p[15:0];
                  if (w < box_acc[0]) box_acc[0] = w;
                  if (w > box_acc[1]) box_acc[1] = w;
                  p = longint'(cy_r) - (y[k] * 256) / zc;
                  w = p[15:0];
                  if (w < box_acc[2]) box_acc[2] = w;
                  if (w > box_acc[3]) box_acc[3] = w;
               end
               bk = 0;
               if (far_r > near_r)
                  bk = (mean - longint'(near_r)) * (NBKT - 1) / (longint'(far_r) - near_r);
               if (bk >= NBKT) bk = NBKT - 1;
               link_ok[idx] = 0;
               if (!head_ok[bk]) begin
                  heads[bk] = idx;
                  head_ok[bk] = 1;
               end else begin
                  links[tails[bk]] = idx;
                  link_ok[tails[bk]] = 1;
               end
               tails[bk] = idx;
               tri_cnt++;
               kept_n++;
               r.bucket = bk[7:0];
            end
         end
      end else begin
         while (!cur_ok && !drain_end) begin
            if (head_ok[drain_b]) begin
               cursor = heads[drain_b];
               cur_ok = 1;
            end
            if (drain_b == 0) drain_end = 1;
            else drain_b--;
         end
         if (cur_ok) begin
            r.idx = cursor[8:0];
            r.valid = 1;
            cur_ok = link_ok[cursor];
            cursor = links[cursor];
         end
      end
      r.kept = kept_n[9:0];
      r.rejn = rej_n[9:0];
      for (int i = 0; i < 4; i++) r.box[i] = box_acc[i][15:0];
      return r;
   endfunction

   function automatic sort_result_type unpack_rsp(logic [103:0] t);
      sort_result_type r;
      r.rej = t[0]; r.bucket = t[8:1]; r.idx = t[17:9]; r.valid = t[18];
      r.kept = t[28:19]; r.rejn = t[38:29];
      for (int i = 0; i < 4; i++) r.box[i] = t[39 + 16*i +: 16];
      return r;
   endfunction

   function automatic logic [143:0] pack_tri(shortint ax, ay, az, bx, by, bz, qx, qy, qz);
      return {qz, qy, qx, bz, by, bx, az, ay, ax};
   endfunction

   // typed result for an item that leaves an empty frame, except possibly rejects
   function automatic sort_result_type empty_frame_res(bit rej, int rejn);
      sort_result_type r;
      r.rej = rej; r.bucket = 0; r.idx = 0; r.valid = 0; r.kept = 0; r.rejn = rejn;
      r.box[0] = 16'sd32767; r.box[1] = -16'sd32768;
      r.box[2] = 16'sd32767; r.box[3] = -16'sd32768;
      return r;
   endfunction

   task automatic csr_write(cfg_idx_type a, longint v);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v[17:0];
      case (a)
         CFG_SIN:  sin_r  = v[17:0];
         CFG_COS:  cos_r  = v[17:0];
         CFG_NEAR: near_r = v[14:0];
         CFG_FAR:  far_r  = v[15:0];
         CFG_FYO:  fyo_r  = v[15:0];
         CFG_VZO:  vzo_r  = v[15:0];
         CFG_CX:   cx_r   = v[9:0];
         default:  cy_r   = v[9:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(longint sn, cs, nr, fr, fy, vz, sx, sy);
      csr_write(CFG_SIN, sn);  csr_write(CFG_COS, cs);
      csr_write(CFG_NEAR, nr); csr_write(CFG_FAR, fr);
      csr_write(CFG_FYO, fy);  csr_write(CFG_VZO, vz);
      csr_write(CFG_CX, sx);   csr_write(CFG_CY, sy);
   endtask

   // wait until every result is back, then let the core settle before a register write
   task automatic drain_wait();
      while (expected_q.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send(op_type op, bit sf, logic [143:0] d, bit typed, sort_result_type tr);
      sort_result_type r;
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= {sf, op};
      do @(posedge clock); while (!req_tready);
      r = sort_step(op, sf, d);
      expected_q.push_back(typed ? tr : r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   function automatic logic [143:0] rand_tri(int span);
      logic [143:0] d;
      for (int i = 0; i < 9; i++) begin
         if (span <= 0) d[16*i +: 16] = $urandom;
         else d[16*i +: 16] = $urandom_range(0, 2 * span) - span;
      end
      return d;
   endfunction

   // random frames: mostly well-formed loads, then a drain past exhaustion
   task automatic run_frames(int nframes, int span);
      sort_result_type none;
      int n;
      for (int f = 0; f < nframes; f++) begin
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++)
            send(OP_LOAD, i == 0 || $urandom_range(0, 30) == 0,
                 rand_tri(($urandom_range(0, 9) == 0) ? 0 : span), 0, none);
         for (int i = 0; i < n + 2; i++)
            send(OP_FETCH, $urandom_range(0, 40) == 0, rand_tri(0), 0, none);
      end
   endtask

   initial begin
      table_row_type tbl[$];
      table_row_type row;
      sort_result_type none;
      logic [143:0] zeros;
      zeros = '0;
      sin_r = 0; cos_r = 18'h30000; near_r = 128; far_r = 2048;
      fyo_r = 55; vzo_r = 300; cx_r = 160; cy_r = 112;
      clear_frame();
      for (int i = 0; i < NTRI; i++) begin links[i] = 0; link_ok[i] = 0; end
      for (int i = 0; i < NBKT; i++) tails[i] = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      row = '{OP_FETCH, 0, zeros, 1, empty_frame_res(0, 0)}; tbl.push_back(row);
      row = '{OP_LOAD, 1, pack_tri(0, 0, 32767, 0, 0, 32767, 0, 0, 32767), 1,
              empty_frame_res(1, 1)}; tbl.push_back(row);
      row = '{OP_LOAD, 0, pack_tri(-32768, -32768, -32768, -32768, -32768, -32768,
              -32768, -32768, -32768), 1, empty_frame_res(1, 2)}; tbl.push_back(row);
      row = '{OP_LOAD, 0, zeros, 0, none}; tbl.push_back(row);
      row = '{OP_LOAD, 0, zeros, 0, none}; tbl.push_back(row);
      row = '{OP_LOAD, 0, pack_tri(100, 30, -1000, -200, 5, -900, 50, -80, -1100), 0, none};
      tbl.push_back(row);
      row = '{OP_LOAD, 0, pack_tri(32767, 32767, 100, -32768, -32768, 0, 1, -1, 172), 0, none};
      tbl.push_back(row);
      row = '{OP_LOAD, 0, pack_tri(0, 0, 172, 0, 0, 172, 0, 0, -1748), 0, none};
      tbl.push_back(row);
      row = '{OP_LOAD, 0, pack_tri(-21846, 21845, -21846, 21845, -21846, 21845,
              -21846, 21845, -21846), 0, none}; tbl.push_back(row);
      row = '{OP_LOAD, 0, zeros, 0, none}; tbl.push_back(row);
      for (int i = 0; i < 7; i++) begin
         row = '{OP_FETCH, 0, zeros, 0, none}; tbl.push_back(row);
      end
      row = '{OP_FETCH, 1, zeros, 1, empty_frame_res(0, 0)}; tbl.push_back(row);
      row = '{OP_LOAD, 1, pack_tri(10, 10, -500, 20, 20, -500, 30, 30, -500), 0, none};
      tbl.push_back(row);
      row = '{OP_FETCH, 0, {9{16'h5555}}, 0, none}; tbl.push_back(row);
      row = '{OP_FETCH, 0, {9{16'hAAAA}}, 0, none}; tbl.push_back(row);
      foreach (tbl[i]) send(tbl[i].op, tbl[i].sf, tbl[i].tri_data, tbl[i].typed,
                            tbl[i].typed_res);
      req_tvalid <= 1'b0;
      drain_wait();

      // quarter turns, projection center at screen corners
      set_config(65536, 0, 200, 3000, -32768, 1600, 1023, 0);
      run_frames(6, 900);
      req_tvalid <= 1'b0;
      drain_wait();
      set_config(-65536, 0, 1, 65535, 32767, 32767, 0, 1023);
      run_frames(5, 20000);
      req_tvalid <= 1'b0;
      drain_wait();
      // equal limits: all kept go to bucket zero
      set_config(45000, 47000, 500, 500, 0, 500, 512, 512);
      run_frames(3, 0);
      for (int i = 0; i < 4; i++) send(OP_LOAD, 0, {9{16'h0000}}, 0, none);
      for (int i = 0; i < 5; i++) send(OP_FETCH, 0, zeros, 0, none);
      req_tvalid <= 1'b0;
      drain_wait();
      // inverted limits: everything rejected
      set_config(-30000, -50000, 32767, 2, -5, -32768, 0, 0);
      run_frames(3, 500);
      req_tvalid <= 1'b0;
      drain_wait();
      set_config(20000, 60000, 32767, 65535, 12, 32767 + 16000, 300, 200);
      csr_write(CFG_VZO, 32767);
      run_frames(3, 300);
      req_tvalid <= 1'b0;
      drain_wait();
      // fill the table past its capacity
      set_config(0, 65536, 128, 2048, 0, 1000, 160, 112);
      for (int i = 0; i < NTRI + 6; i++)
         send(OP_LOAD, i == 0, rand_tri(300), 0, none);
      for (int i = 0; i < 12; i++) send(OP_FETCH, 0, zeros, 0, none);
      send(OP_LOAD, 1, rand_tri(300), 0, none);
      send(OP_FETCH, 0, zeros, 0, none);
      send(OP_FETCH, 0, zeros, 0, none);
      req_tvalid <= 1'b0;

      while (expected_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // result side: check, long hold-off once, shifting stall pattern
   always @(posedge clock) begin
      sort_result_type got, want;
      bit bad;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = unpack_rsp(rsp_tdata);
         rsp_count++;
         if (rsp_count == 60) hold_left = 600;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer %h", rsp_tdata);
         end else begin
            want = expected_q.pop_front();
            bad = got.rej != want.rej || got.bucket != want.bucket || got.idx != want.idx ||
                  got.valid != want.valid || got.kept != want.kept || got.rejn != want.rejn;
            for (int i = 0; i < 4; i++) bad |= got.box[i] != want.box[i];
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch #%0d exp rej=%0d bkt=%0d idx=%0d v=%0d k=%0d r=%0d",
                           rsp_count, want.rej, want.bucket, want.idx, want.valid,
                           want.kept, want.rejn);
                  $display("   exp box=%0d %0d %0d %0d", want.box[0], want.box[1],
                           want.box[2], want.box[3]);
                  $display("   got rej=%0d bkt=%0d idx=%0d v=%0d k=%0d r=%0d",
                           got.rej, got.bucket, got.idx, got.valid, got.kept, got.rejn);
                  $display("   got box=%0d %0d %0d %0d", got.box[0], got.box[1],
                           got.box[2], got.box[3]);
               end
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (cycles[9:8])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= $urandom_range(0, 1);
            2'd2:    rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

endmodule
